// ===== rtl/slu_pkg.sv =====
// types and constants shared by the serial line unit
`default_nettype none
package slu_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINE  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_RX_STATUS = 2'd0,
    REG_RX_BUFFER = 2'd1,
    REG_TX_STATUS = 2'd2,
    REG_TX_BUFFER = 2'd3
  } reg_t;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned CHAR_W = 8;

  localparam logic [WORD_W-1:0] CHAR_TIME_RESET = 16'd1000;

  // rx status bits
  localparam int unsigned RX_RDR_ENB_BIT  = 0;
  localparam int unsigned RX_DSET_IE_BIT  = 5;
  localparam int unsigned RX_IE_BIT       = 6;
  localparam int unsigned RX_DONE_BIT     = 7;
  localparam int unsigned RX_ACTIVE_BIT   = 11;
  localparam int unsigned RX_DSET_INT_BIT = 15;
  localparam logic [WORD_W-1:0] RX_WR_MASK = 16'h006E;

  // rx buffer flags
  localparam int unsigned RB_OVERRUN_BIT = 14;
  localparam int unsigned RB_ERROR_BIT   = 15;

  // tx status bits
  localparam int unsigned TX_MAINT_BIT = 2;
  localparam int unsigned TX_IE_BIT    = 6;
  localparam int unsigned TX_READY_BIT = 7;
  localparam logic [WORD_W-1:0] TX_WR_MASK  = 16'h0045;
  localparam logic [WORD_W-1:0] TX_STATUS_RESET = 16'h0080;

  typedef struct packed {
    op_t               operation;
    reg_t              reg_index;
    logic [WORD_W-1:0] write_data;
    logic [CHAR_W-1:0] line_char;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              irq;
    logic              tx_valid;
    logic [CHAR_W-1:0] tx_char;
    logic              rx_accepted;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/slu_ifs.sv =====
// request, result and configuration channel interfaces of the serial line unit
`default_nettype none
interface slu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  reg_index;
  logic [15:0] write_data;
  logic [7:0]  line_char;
  modport source (output valid, operation, reg_index, write_data, line_char, input ready);
  modport sink   (input valid, operation, reg_index, write_data, line_char, output ready);
endinterface

interface slu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        irq;
  logic        tx_valid;
  logic [7:0]  tx_char;
  logic        rx_accepted;
  modport source (output valid, read_data, irq, tx_valid, tx_char, rx_accepted, input ready);
  modport sink   (input valid, read_data, irq, tx_valid, tx_char, rx_accepted, output ready);
endinterface

interface slu_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/slu_core.sv =====
// register file, character timers and result logic of the serial line unit
`default_nettype none
module slu_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       fire,
  input  wire slu_pkg::item_t             item,
  input  wire logic                       cfg_we,
  input  wire logic [slu_pkg::WORD_W-1:0] cfg_data,
  output slu_pkg::result_t                result
);

  localparam int unsigned LW = (COUNT_BITS > slu_pkg::WORD_W) ? COUNT_BITS : slu_pkg::WORD_W;
  localparam logic [LW-1:0] CNT_MAX = LW'({COUNT_BITS{1'b1}});

  logic [slu_pkg::WORD_W-1:0] char_time_r;
  logic [slu_pkg::WORD_W-1:0] rx_status_r, rx_status_nxt;
  logic [slu_pkg::WORD_W-1:0] rx_buffer_r, rx_buffer_nxt;
  logic [slu_pkg::WORD_W-1:0] tx_status_r, tx_status_nxt;
  logic [slu_pkg::CHAR_W-1:0] tx_buffer_r, tx_buffer_nxt;
  logic [slu_pkg::CHAR_W-1:0] rx_shift_r, rx_shift_nxt;
  logic [slu_pkg::CHAR_W-1:0] tx_shift_r, tx_shift_nxt;
  logic                       tx_pending_r, tx_pending_nxt;
  logic [COUNT_BITS-1:0]      rx_cnt_r, rx_cnt_nxt;
  logic [COUNT_BITS-1:0]      tx_cnt_r, tx_cnt_nxt;

  logic [LW-1:0]         ct_ext;
  logic [COUNT_BITS-1:0] load_val;

  // zero acts as one, too large saturates
  always_comb begin
    ct_ext = LW'(char_time_r);
    if (ct_ext == '0) begin
      load_val = COUNT_BITS'(1);
    end else if (ct_ext > CNT_MAX) begin
      load_val = CNT_MAX[COUNT_BITS-1:0];
    end else begin
      load_val = ct_ext[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    logic rx_fire;
    logic tx_fire;
    logic [slu_pkg::WORD_W-1:0] rd;
    logic txv;
    logic [slu_pkg::CHAR_W-1:0] txc;
    logic acc;
    rx_status_nxt  = rx_status_r;
    rx_buffer_nxt  = rx_buffer_r;
    tx_status_nxt  = tx_status_r;
    tx_buffer_nxt  = tx_buffer_r;
    rx_shift_nxt   = rx_shift_r;
    tx_shift_nxt   = tx_shift_r;
    tx_pending_nxt = tx_pending_r;
    rx_cnt_nxt     = rx_cnt_r;
    tx_cnt_nxt     = tx_cnt_r;
    rx_fire = 1'b0;
    tx_fire = 1'b0;
    rd  = '0;
    txv = 1'b0;
    txc = '0;
    acc = 1'b0;
    unique case (item.operation)
      slu_pkg::OP_READ: begin
        unique case (item.reg_index)
          slu_pkg::REG_RX_STATUS: begin
            rd = rx_status_r;
            rx_status_nxt[slu_pkg::RX_DSET_INT_BIT] = 1'b0;
          end
          slu_pkg::REG_RX_BUFFER: begin
            rd = rx_buffer_r;
            rx_status_nxt[slu_pkg::RX_DONE_BIT] = 1'b0;
          end
          slu_pkg::REG_TX_STATUS: rd = tx_status_r;
          default: rd = slu_pkg::WORD_W'(tx_buffer_r);
        endcase
      end
      slu_pkg::OP_WRITE: begin
        unique case (item.reg_index)
          slu_pkg::REG_RX_STATUS: begin
            rx_status_nxt = (rx_status_r & ~slu_pkg::RX_WR_MASK) |
                            (item.write_data & slu_pkg::RX_WR_MASK);
            if (item.write_data[slu_pkg::RX_RDR_ENB_BIT]) begin
              rx_status_nxt[slu_pkg::RX_DONE_BIT] = 1'b0;
            end
          end
          slu_pkg::REG_RX_BUFFER: rx_status_nxt[slu_pkg::RX_DONE_BIT] = 1'b0;
          slu_pkg::REG_TX_STATUS: begin
            tx_status_nxt = (tx_status_r & slu_pkg::TX_STATUS_RESET) |
                            (item.write_data & slu_pkg::TX_WR_MASK);
            // entering maintenance cancels a receive in progress
            if (item.write_data[slu_pkg::TX_MAINT_BIT]) begin
              rx_cnt_nxt = '0;
              rx_status_nxt[slu_pkg::RX_ACTIVE_BIT] = 1'b0;
            end
          end
          default: begin
            tx_buffer_nxt = item.write_data[slu_pkg::CHAR_W-1:0];
            if (!tx_status_r[slu_pkg::TX_READY_BIT]) begin
              tx_pending_nxt = 1'b1;
            end else begin
              tx_pending_nxt = 1'b0;
              tx_status_nxt[slu_pkg::TX_READY_BIT] = 1'b0;
              tx_shift_nxt = item.write_data[slu_pkg::CHAR_W-1:0];
              tx_cnt_nxt = load_val;
              if (tx_status_r[slu_pkg::TX_MAINT_BIT]) begin
                rx_shift_nxt = item.write_data[slu_pkg::CHAR_W-1:0];
                rx_status_nxt[slu_pkg::RX_ACTIVE_BIT] = 1'b1;
                rx_cnt_nxt = load_val;
              end
            end
          end
        endcase
      end
      slu_pkg::OP_LINE: begin
        if (rx_cnt_r == '0) begin
          acc = 1'b1;
          // in maintenance the line character is dropped
          if (!tx_status_r[slu_pkg::TX_MAINT_BIT]) begin
            rx_shift_nxt = item.line_char;
            rx_status_nxt[slu_pkg::RX_ACTIVE_BIT] = 1'b1;
            rx_cnt_nxt = load_val;
          end
        end
      end
      default: begin
        if (rx_cnt_r != '0) begin
          rx_cnt_nxt = rx_cnt_r - COUNT_BITS'(1);
          rx_fire = (rx_cnt_r == COUNT_BITS'(1));
        end
        if (tx_cnt_r != '0) begin
          tx_cnt_nxt = tx_cnt_r - COUNT_BITS'(1);
          tx_fire = (tx_cnt_r == COUNT_BITS'(1));
        end
        // receiver completes before the transmitter
        if (rx_fire) begin
          rx_buffer_nxt = '0;
          if (rx_status_r[slu_pkg::RX_DONE_BIT]) begin
            rx_buffer_nxt[slu_pkg::RB_OVERRUN_BIT] = 1'b1;
            rx_buffer_nxt[slu_pkg::RB_ERROR_BIT]   = 1'b1;
          end
          rx_buffer_nxt[slu_pkg::CHAR_W-1:0] = rx_shift_r;
          rx_status_nxt[slu_pkg::RX_ACTIVE_BIT] = 1'b0;
          rx_status_nxt[slu_pkg::RX_DONE_BIT]   = 1'b1;
        end
        if (tx_fire) begin
          if (!tx_status_r[slu_pkg::TX_MAINT_BIT]) begin
            txv = 1'b1;
            txc = tx_shift_r;
          end
          tx_status_nxt[slu_pkg::TX_READY_BIT] = 1'b1;
          // pending character starts right away, looped back in maintenance
          if (tx_pending_r) begin
            tx_pending_nxt = 1'b0;
            tx_status_nxt[slu_pkg::TX_READY_BIT] = 1'b0;
            tx_shift_nxt = tx_buffer_r;
            tx_cnt_nxt = load_val;
            if (tx_status_r[slu_pkg::TX_MAINT_BIT]) begin
              rx_shift_nxt = tx_buffer_r;
              rx_status_nxt[slu_pkg::RX_ACTIVE_BIT] = 1'b1;
              rx_cnt_nxt = load_val;
            end
          end
        end
      end
    endcase
    result.read_data   = rd;
    result.irq = (rx_status_nxt[slu_pkg::RX_DSET_IE_BIT] &
                  rx_status_nxt[slu_pkg::RX_DSET_INT_BIT]) |
                 (rx_status_nxt[slu_pkg::RX_IE_BIT] & rx_status_nxt[slu_pkg::RX_DONE_BIT]) |
                 (tx_status_nxt[slu_pkg::TX_IE_BIT] & tx_status_nxt[slu_pkg::TX_READY_BIT]);
    result.tx_valid    = txv;
    result.tx_char     = txc;
    result.rx_accepted = acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_time_r  <= slu_pkg::CHAR_TIME_RESET;
      rx_status_r  <= '0;
      rx_buffer_r  <= '0;
      tx_status_r  <= slu_pkg::TX_STATUS_RESET;
      tx_buffer_r  <= '0;
      rx_shift_r   <= '0;
      tx_shift_r   <= '0;
      tx_pending_r <= 1'b0;
      rx_cnt_r     <= '0;
      tx_cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        char_time_r <= cfg_data;
      end
      if (fire) begin
        rx_status_r  <= rx_status_nxt;
        rx_buffer_r  <= rx_buffer_nxt;
        tx_status_r  <= tx_status_nxt;
        tx_buffer_r  <= tx_buffer_nxt;
        rx_shift_r   <= rx_shift_nxt;
        tx_shift_r   <= tx_shift_nxt;
        tx_pending_r <= tx_pending_nxt;
        rx_cnt_r     <= rx_cnt_nxt;
        tx_cnt_r     <= tx_cnt_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/serial_line_unit_registers.sv =====
// top level of the serial line unit: request register, core and result register
//
//  channel | dir | payload                                       | handshake
//  in_if   | in  | operation, reg_index, write_data, line_char   | valid/ready
//  out_if  | out | read_data, irq, tx_valid, tx_char, rx_accepted | valid/ready
//  cfg_if  | in  | data (char_time)                              | valid/ready, always ready
//
// one request per cycle unless out_if stalls; each taken request passes the request
// register, then the result register, from which it is offered on out_if.
// rst_n (synchronous) clears the registers, the timers and both pipeline stages.
// while out_if.ready is low the result holds, one more request is buffered,
// then in_if.ready drops.
`default_nettype none
module serial_line_unit_registers #(
  parameter int unsigned COUNT_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  slu_in_if.sink    in_if,
  slu_out_if.source out_if,
  slu_cfg_if.sink   cfg_if
);

  logic              req_valid_r;
  slu_pkg::item_t    req_r;
  logic              res_valid_r;
  slu_pkg::result_t  res_r;
  slu_pkg::result_t  core_res;
  logic              advance;
  logic              fire;

  assign advance = !res_valid_r || out_if.ready;
  assign fire    = req_valid_r && advance;
  assign in_if.ready  = !req_valid_r || advance;
  assign cfg_if.ready = 1'b1;

  slu_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (req_r),
    .cfg_we   (cfg_if.valid),
    .cfg_data (cfg_if.data),
    .result   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        req_valid_r <= in_if.valid;
      end
      if (advance) begin
        res_valid_r <= req_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      req_r.operation  <= slu_pkg::op_t'(in_if.operation);
      req_r.reg_index  <= slu_pkg::reg_t'(in_if.reg_index);
      req_r.write_data <= in_if.write_data;
      req_r.line_char  <= in_if.line_char;
    end
    if (fire) begin
      res_r <= core_res;
    end
  end

  assign out_if.valid       = res_valid_r;
  assign out_if.read_data   = res_r.read_data;
  assign out_if.irq         = res_r.irq;
  assign out_if.tx_valid    = res_r.tx_valid;
  assign out_if.tx_char     = res_r.tx_char;
  assign out_if.rx_accepted = res_r.rx_accepted;

endmodule
`default_nettype wire

// ===== tb/tb_serial_line_unit_registers.sv =====
// self-checking testbench for the serial line unit register block
module tb_serial_line_unit_registers;
  import slu_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 400;

  logic clk;
  logic rst_n;

  slu_in_if  in_if();
  slu_out_if out_if();
  slu_cfg_if cfg_if();

  serial_line_unit_registers DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // predicted register file and timers
  logic [WORD_W-1:0] char_time_q;
  logic [WORD_W-1:0] rx_status_q;
  logic [WORD_W-1:0] rx_buffer_q;
  logic [WORD_W-1:0] tx_status_q;
  logic [CHAR_W-1:0] tx_buffer_q;
  logic [CHAR_W-1:0] rx_shift_q;
  logic [CHAR_W-1:0] tx_shift_q;
  logic              tx_pend_q;
  logic [WORD_W-1:0] rx_count_q;
  logic [WORD_W-1:0] tx_count_q;

  item_t   pending_reqs[$];
  result_t awaited_responses[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_arm = 1'b0;
  int unsigned idle_cycles = 0;

  int unsigned queued_reqs = 0;
  int unsigned taken_reqs = 0;
  int unsigned checked_responses = 0;
  int unsigned fail_count = 0;
  int unsigned char_time_writes = 0;
  int unsigned chars_out = 0;
  int unsigned irq_seen = 0;
  int unsigned line_refused = 0;
  int unsigned overruns = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] ticks_per_char();
    return (char_time_q == '0) ? WORD_W'(1) : char_time_q;
  endfunction

  task automatic start_char_in(input logic [CHAR_W-1:0] ch);
    rx_shift_q = ch;
    rx_status_q[RX_ACTIVE_BIT] = 1'b1;
    rx_count_q = ticks_per_char();
  endtask

  task automatic start_char_out();
    if (!tx_status_q[TX_READY_BIT]) begin
      tx_pend_q = 1'b1;
    end else begin
      tx_pend_q = 1'b0;
      tx_status_q[TX_READY_BIT] = 1'b0;
      tx_shift_q = tx_buffer_q;
      tx_count_q = ticks_per_char();
      // maintenance loops the character straight back into the receiver
      if (tx_status_q[TX_MAINT_BIT]) begin
        start_char_in(tx_shift_q);
      end
    end
  endtask

  task automatic predict_slu_response(input item_t req, output result_t rsp);
    logic rx_fire;
    logic tx_fire;
    rsp = '0;
    rx_fire = 1'b0;
    tx_fire = 1'b0;
    case (req.operation)
      OP_READ: begin
        case (req.reg_index)
          REG_RX_STATUS: begin
            rsp.read_data = rx_status_q;
            rx_status_q[RX_DSET_INT_BIT] = 1'b0;
          end
          REG_RX_BUFFER: begin
            rsp.read_data = rx_buffer_q;
            rx_status_q[RX_DONE_BIT] = 1'b0;
          end
          REG_TX_STATUS: rsp.read_data = tx_status_q;
          default: rsp.read_data = {8'h00, tx_buffer_q};
        endcase
      end
      OP_WRITE: begin
        case (req.reg_index)
          REG_RX_STATUS: begin
            rx_status_q = (rx_status_q & ~RX_WR_MASK) | (req.write_data & RX_WR_MASK);
            if (req.write_data[RX_RDR_ENB_BIT]) begin
              rx_status_q[RX_DONE_BIT] = 1'b0;
            end
          end
          REG_RX_BUFFER: rx_status_q[RX_DONE_BIT] = 1'b0;
          REG_TX_STATUS: begin
            tx_status_q = (req.write_data & TX_WR_MASK) |
                          (tx_status_q & (WORD_W'(1) << TX_READY_BIT));
            if (req.write_data[TX_MAINT_BIT]) begin
              rx_count_q = '0;
              rx_status_q[RX_ACTIVE_BIT] = 1'b0;
            end
          end
          default: begin
            tx_buffer_q = req.write_data[CHAR_W-1:0];
            start_char_out();
          end
        endcase
      end
      OP_LINE: begin
        if (rx_count_q == '0) begin
          rsp.rx_accepted = 1'b1;
          if (!tx_status_q[TX_MAINT_BIT]) begin
            start_char_in(req.line_char);
          end
        end else begin
          line_refused++;
        end
      end
      default: begin
        if (rx_count_q != '0) begin
          rx_count_q = rx_count_q - 1'b1;
          rx_fire = (rx_count_q == '0);
        end
        if (tx_count_q != '0) begin
          tx_count_q = tx_count_q - 1'b1;
          tx_fire = (tx_count_q == '0);
        end
        // receiver completes before the transmitter on a shared tick
        if (rx_fire) begin
          rx_buffer_q = {8'h00, rx_shift_q};
          if (rx_status_q[RX_DONE_BIT]) begin
            rx_buffer_q[RB_OVERRUN_BIT] = 1'b1;
            rx_buffer_q[RB_ERROR_BIT] = 1'b1;
            overruns++;
          end
          rx_status_q[RX_ACTIVE_BIT] = 1'b0;
          rx_status_q[RX_DONE_BIT] = 1'b1;
        end
        if (tx_fire) begin
          if (!tx_status_q[TX_MAINT_BIT]) begin
            rsp.tx_valid = 1'b1;
            rsp.tx_char = tx_shift_q;
          end
          tx_status_q[TX_READY_BIT] = 1'b1;
          if (tx_pend_q) begin
            start_char_out();
          end
        end
      end
    endcase
    rsp.irq = (rx_status_q[RX_DSET_IE_BIT] & rx_status_q[RX_DSET_INT_BIT]) |
              (rx_status_q[RX_IE_BIT] & rx_status_q[RX_DONE_BIT]) |
              (tx_status_q[TX_IE_BIT] & tx_status_q[TX_READY_BIT]);
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    item_t   taken;
    result_t rsp;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        taken = {in_if.operation, in_if.reg_index, in_if.write_data, in_if.line_char};
        predict_slu_response(taken, rsp);
        awaited_responses.push_back(rsp);
        taken_reqs++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          taken = pending_reqs.pop_front();
          in_if.valid      <= 1'b1;
          in_if.operation  <= taken.operation;
          in_if.reg_index  <= taken.reg_index;
          in_if.write_data <= taken.write_data;
          in_if.line_char  <= taken.line_char;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_responses
    result_t exp;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (awaited_responses.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp = awaited_responses.pop_front();
          checked_responses++;
          if (out_if.read_data !== exp.read_data) begin
            $error("read_data: expected %h, got %h", exp.read_data, out_if.read_data);
            fail_count++;
          end
          if (out_if.irq !== exp.irq) begin
            $error("irq: expected %b, got %b", exp.irq, out_if.irq);
            fail_count++;
          end
          if (out_if.tx_valid !== exp.tx_valid) begin
            $error("tx_valid: expected %b, got %b", exp.tx_valid, out_if.tx_valid);
            fail_count++;
          end
          if (out_if.tx_char !== exp.tx_char) begin
            $error("tx_char: expected %h, got %h", exp.tx_char, out_if.tx_char);
            fail_count++;
          end
          if (out_if.rx_accepted !== exp.rx_accepted) begin
            $error("rx_accepted: expected %b, got %b", exp.rx_accepted, out_if.rx_accepted);
            fail_count++;
          end
          if (exp.tx_valid) chars_out++;
          if (exp.irq) irq_seen++;
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long output hold-off, counted here so the sender keeps running
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      hold_left <= LONG_HOLD;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_serial_line_unit_registers NOT OK");
        $finish;
      end
    end
  end

  task automatic add_req(input op_t op, input reg_t r, input logic [WORD_W-1:0] d,
                         input logic [CHAR_W-1:0] c);
    item_t req;
    req.operation  = op;
    req.reg_index  = r;
    req.write_data = d;
    req.line_char  = c;
    pending_reqs.push_back(req);
    queued_reqs++;
  endtask

  task automatic add_ticks(input int unsigned n);
    repeat (n) add_req(OP_TICK, reg_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_if.valid || awaited_responses.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_char_time(input logic [WORD_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    char_time_q = value;
    char_time_writes++;
  endtask

  // mostly whole character exchanges with random content, some plain noise and control writes
  task automatic queue_traffic(input int unsigned n_items, input logic [WORD_W-1:0] ct);
    int unsigned target;
    int unsigned span;
    int unsigned pick;
    logic [WORD_W-1:0] wd;
    target = queued_reqs + n_items;
    span = (ct == '0) ? 1 : ((ct > 10) ? 10 : ct);
    while (queued_reqs < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        add_req(op_t'($urandom_range(0, 3)), reg_t'($urandom_range(0, 3)),
                16'($urandom), 8'($urandom));
      end else if (pick < 6) begin
        add_req(OP_LINE, reg_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
        add_ticks($urandom_range(span - 1, span + 1));
        if ($urandom_range(0, 1)) add_req(OP_READ, REG_RX_STATUS, 16'($urandom), 8'($urandom));
        pick = $urandom_range(0, 4);
        if (pick < 3) begin
          add_req(OP_READ, REG_RX_BUFFER, 16'($urandom), 8'($urandom));
        end else if (pick == 3) begin
          wd = 16'($urandom);
          wd[RX_RDR_ENB_BIT] = 1'b1;
          add_req(OP_WRITE, REG_RX_STATUS, wd, 8'($urandom));
        end
      end else if (pick < 9) begin
        add_req(OP_WRITE, REG_TX_BUFFER, 16'($urandom), 8'($urandom));
        if ($urandom_range(0, 9) < 3) begin
          add_req(OP_WRITE, REG_TX_BUFFER, 16'($urandom), 8'($urandom));
        end
        add_ticks($urandom_range(span - 1, 2 * span + 1));
        if ($urandom_range(0, 1)) add_req(OP_READ, REG_TX_STATUS, 16'($urandom), 8'($urandom));
        if ($urandom_range(0, 4) == 0) begin
          add_req(OP_READ, REG_TX_BUFFER, 16'($urandom), 8'($urandom));
        end
      end else begin
        wd = 16'($urandom);
        if ($urandom_range(0, 1)) begin
          add_req(OP_WRITE, REG_RX_STATUS, wd, 8'($urandom));
        end else begin
          // maintenance kills the receiver, so keep it rare
          wd[TX_MAINT_BIT] = ($urandom_range(0, 9) == 0);
          add_req(OP_WRITE, REG_TX_STATUS, wd, 8'($urandom));
        end
      end
    end
  endtask

  task automatic run_phase(input logic [WORD_W-1:0] ct, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned n_items,
                           input bit pressure);
    wait_drained();
    repeat (4) @(posedge clk);
    write_char_time(ct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (pressure) begin
      queue_traffic(n_items / 2, ct);
      @(posedge clk);
      hold_arm <= 1'b1;
      while (hold_left == 0) @(posedge clk);
      hold_arm <= 1'b0;
      // sender waits for every result before the second half
      wait_drained();
      queue_traffic(n_items - n_items / 2, ct);
    end else begin
      queue_traffic(n_items, ct);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = '0;
    in_if.reg_index = '0;
    in_if.write_data = '0;
    in_if.line_char = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    char_time_q = CHAR_TIME_RESET;
    rx_status_q = '0;
    rx_buffer_q = '0;
    tx_status_q = TX_STATUS_RESET;
    tx_buffer_q = '0;
    rx_shift_q = '0;
    tx_shift_q = '0;
    tx_pend_q = 1'b0;
    rx_count_q = '0;
    tx_count_q = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset character time: reads, control writes, busy receiver, maintenance
    add_req(OP_READ, REG_RX_STATUS, 16'h0000, 8'h00);
    add_req(OP_READ, REG_RX_BUFFER, 16'hFFFF, 8'hFF);
    add_req(OP_READ, REG_TX_STATUS, 16'h0000, 8'h00);
    add_req(OP_READ, REG_TX_BUFFER, 16'h0000, 8'h00);
    add_req(OP_WRITE, REG_RX_STATUS, 16'hFFFF, 8'h00);
    add_req(OP_LINE, REG_RX_STATUS, 16'h0000, 8'hFF);
    add_req(OP_LINE, REG_TX_BUFFER, 16'hFFFF, 8'h00);
    add_req(OP_WRITE, REG_TX_STATUS, 16'h0004, 8'h00);
    add_req(OP_LINE, REG_RX_STATUS, 16'h0000, 8'h5A);
    add_req(OP_WRITE, REG_TX_STATUS, 16'h0041, 8'h00);
    add_req(OP_READ, REG_RX_STATUS, 16'h0000, 8'h00);
    wait_drained();
    repeat (4) @(posedge clk);

    // zero character time acts as one tick
    write_char_time(16'h0000);
    add_req(OP_WRITE, REG_TX_BUFFER, 16'h00A5, 8'h00);
    add_req(OP_WRITE, REG_TX_BUFFER, 16'h003C, 8'h00);
    add_req(OP_WRITE, REG_TX_BUFFER, 16'hFFC3, 8'h00);
    add_req(OP_LINE, REG_RX_STATUS, 16'h0000, 8'h81);
    add_req(OP_TICK, REG_RX_STATUS, 16'h0000, 8'h00);
    add_req(OP_LINE, REG_RX_STATUS, 16'h0000, 8'h42);
    add_req(OP_TICK, REG_TX_BUFFER, 16'hFFFF, 8'hFF);
    add_req(OP_READ, REG_RX_BUFFER, 16'h0000, 8'h00);
    add_req(OP_WRITE, REG_RX_BUFFER, 16'hFFFF, 8'hFF);
    add_req(OP_WRITE, REG_TX_STATUS, 16'h0044, 8'h00);
    add_req(OP_WRITE, REG_TX_BUFFER, 16'h0077, 8'h00);
    add_req(OP_TICK, REG_RX_STATUS, 16'h0000, 8'h00);
    add_req(OP_READ, REG_RX_BUFFER, 16'h0000, 8'h00);
    add_req(OP_WRITE, REG_RX_STATUS, 16'h0001, 8'h00);
    add_req(OP_WRITE, REG_TX_STATUS, 16'h0000, 8'h00);
    add_req(OP_TICK, REG_RX_STATUS, 16'h0000, 8'h00);

    run_phase(16'd1, 0, 0, 300, 1'b0);
    run_phase(16'd3, 78, 0, 300, 1'b0);
    run_phase(16'hFFFF, 0, 78, 150, 1'b0);
    run_phase(16'd2, 12, 12, 300, 1'b1);
    run_phase(16'($urandom_range(1, 8)), 0, 0, 300, 1'b0);
    run_phase(16'd5, 12, 12, 350, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d character time settings",
             taken_reqs, checked_responses, char_time_writes);
    $display("chars to line %0d, line chars refused %0d, overruns %0d, irq high %0d",
             chars_out, line_refused, overruns, irq_seen);
    if (fail_count == 0 && awaited_responses.size() == 0) begin
      $display("tb_serial_line_unit_registers OK");
    end else begin
      $display("tb_serial_line_unit_registers NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/slu_pkg.sv
rtl/slu_ifs.sv
rtl/slu_core.sv
rtl/serial_line_unit_registers.sv
tb/tb_serial_line_unit_registers.sv
